// ===== rtl/core/two_sided_quote_refresher_core_assert.svh =====
// ----------------------------------------------------------------------------
// Two-sided quote refresher assertion macros
// Shared concurrent assertion forms, clocked on clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef TWO_SIDED_QUOTE_REFRESHER_CORE_ASSERT_SVH
`define TWO_SIDED_QUOTE_REFRESHER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSQR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tsqr assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TSQR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tsqr assertion failed");

`endif

// ===== rtl/core/tsqr_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-sided quote refresher package
// Command codes, action codes, register indexes and side interface types.
// ----------------------------------------------------------------------------
package tsqr_pkg;

	localparam int PRICE_W = 32;
	localparam int ID_W    = 32;
	localparam int QTY_W   = 32;
	localparam int TIME_W  = 64;

	typedef enum logic [1:0] {
		CMD_BOOK   = 2'd0,
		CMD_ACK    = 2'd1,
		CMD_FILL   = 2'd2,
		CMD_REJECT = 2'd3
	} cmd_t;

	localparam logic ACT_CANCEL = 1'b0;
	localparam logic ACT_POST   = 1'b1;

	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	localparam logic REG_VENUE = 1'b0;
	localparam logic REG_QSIZE = 1'b1;

	localparam logic [1:0] SLOT_BUY_CANCEL  = 2'd0;
	localparam logic [1:0] SLOT_BUY_POST    = 2'd1;
	localparam logic [1:0] SLOT_SELL_CANCEL = 2'd2;
	localparam logic [1:0] SLOT_SELL_POST   = 2'd3;

	typedef struct packed {
		logic            refresh;
		logic            ack;
		logic            reject;
		logic            fill;
		logic [ID_W-1:0] id;
	} side_ctl_t;

	typedef struct packed {
		logic            post;
		logic            cancel;
		logic [ID_W-1:0] cancel_id;
	} side_dec_t;

endpackage

// ===== rtl/core/tsqr_side.sv =====
// ----------------------------------------------------------------------------
// Quote side
// Holds one side's waiting flag, resting id and target, and decides whether
// a book update must cancel and repost that side.
// ----------------------------------------------------------------------------
module tsqr_side (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tsqr_pkg::side_ctl_t          ctl,
	input  logic [tsqr_pkg::PRICE_W-1:0] target,
	output tsqr_pkg::side_dec_t          dec
);

	logic                         waiting_q;
	logic [tsqr_pkg::ID_W-1:0]    resting_q;
	logic [tsqr_pkg::PRICE_W-1:0] target_q;
	logic                         has_order;
	logic                         at_target;

	assign has_order     = (resting_q != '0);
	assign at_target     = has_order && (target_q == target);
	assign dec.post      = !waiting_q && !at_target;
	assign dec.cancel    = dec.post && has_order;
	assign dec.cancel_id = resting_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q <= 1'b0;
			resting_q <= '0;
			target_q  <= '0;
		end else if (ctl.refresh && dec.post) begin
			waiting_q <= 1'b1;
			resting_q <= '0;
			target_q  <= target;
		end else if (ctl.ack) begin
			waiting_q <= 1'b0;
			resting_q <= ctl.id;
		end else if (ctl.reject) begin
			waiting_q <= 1'b0;
			target_q  <= '0;
		end else if (ctl.fill && (ctl.id == resting_q)) begin
			resting_q <= '0;
			target_q  <= '0;
		end
	end

endmodule

// ===== rtl/core/two_sided_quote_refresher_core.sv =====
// ----------------------------------------------------------------------------
// Two-sided quote refresher core
// A result word passes the input stage, the result buffer and the output register.
// Throughput: one input word per cycle; a book update causing actions (up to four)
// waits until the result buffer is free, and the buffer sends them out one at a time.
// Reset clears quotes, the acknowledgement queue count, the buffers and the registers
// to their defaults (venue detached, quote size one).
// ----------------------------------------------------------------------------
module two_sided_quote_refresher_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_index,
	input  logic [31:0]                         cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          cmd,
	input  logic                                book_empty,
	input  logic signed [tsqr_pkg::PRICE_W-1:0] bid_px,
	input  logic signed [tsqr_pkg::PRICE_W-1:0] ask_px,
	input  logic [tsqr_pkg::ID_W-1:0]           order_id,
	input  logic                                fill_side,
	input  logic [tsqr_pkg::TIME_W-1:0]         event_time,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                action,
	output logic                                action_side,
	output logic [tsqr_pkg::ID_W-1:0]           cancel_id,
	output logic signed [tsqr_pkg::PRICE_W-1:0] quote_price,
	output logic [tsqr_pkg::QTY_W-1:0]          quote_qty,
	output logic [tsqr_pkg::TIME_W-1:0]         action_time,
	output logic                                last
);

	logic                         venue_q;
	logic [tsqr_pkg::QTY_W-1:0]   qsize_q;

	logic                         valid_s1;
	tsqr_pkg::cmd_t               cmd_s1;
	logic                         empty_s1;
	logic [tsqr_pkg::PRICE_W-1:0] bid_s1;
	logic [tsqr_pkg::PRICE_W-1:0] ask_s1;
	logic [tsqr_pkg::ID_W-1:0]    id_s1;
	logic                         fside_s1;
	logic [tsqr_pkg::TIME_W-1:0]  time_s1;

	logic [1:0]                   qcnt_q;
	logic                         qside0_q;
	logic                         qside1_q;
	logic [1:0]                   qcnt_n;
	logic                         qside0_n;
	logic                         qside1_n;

	logic [3:0]                   mask_q;
	logic [tsqr_pkg::ID_W-1:0]    buy_id_q;
	logic [tsqr_pkg::ID_W-1:0]    sell_id_q;
	logic [tsqr_pkg::PRICE_W-1:0] buy_px_q;
	logic [tsqr_pkg::PRICE_W-1:0] sell_px_q;
	logic [tsqr_pkg::TIME_W-1:0]  time_q;

	logic                         out_valid_q;
	logic                         action_q;
	logic                         side_q;
	logic [tsqr_pkg::ID_W-1:0]    cancel_id_q;
	logic [tsqr_pkg::PRICE_W-1:0] price_q;
	logic [tsqr_pkg::QTY_W-1:0]   qty_q;
	logic [tsqr_pkg::TIME_W-1:0]  out_time_q;
	logic                         last_q;

	logic [tsqr_pkg::PRICE_W-1:0] buy_tgt;
	logic [tsqr_pkg::PRICE_W-1:0] sell_tgt;
	tsqr_pkg::side_ctl_t          buy_ctl;
	tsqr_pkg::side_ctl_t          sell_ctl;
	tsqr_pkg::side_dec_t          buy_dec;
	tsqr_pkg::side_dec_t          sell_dec;

	logic                         book_go;
	logic                         produces;
	logic                         s1_fire;
	logic                         refresh;
	logic                         pop;
	logic [3:0]                   new_mask;
	logic [1:0]                   slot;
	logic [3:0]                   rest_mask;
	logic                         out_load;
	logic                         buf_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			venue_q <= 1'b0;
			qsize_q <= 32'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				tsqr_pkg::REG_VENUE: venue_q <= cfg_data[0];
				tsqr_pkg::REG_QSIZE: qsize_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1   <= tsqr_pkg::cmd_t'(cmd);
			empty_s1 <= book_empty;
			bid_s1   <= bid_px;
			ask_s1   <= ask_px;
			id_s1    <= order_id;
			fside_s1 <= fill_side;
			time_s1  <= event_time;
		end
	end

	assign buy_tgt  = bid_s1 - 32'd1;
	assign sell_tgt = ask_s1 + 32'd1;

	assign book_go  = valid_s1 && (cmd_s1 == tsqr_pkg::CMD_BOOK) && !empty_s1 && venue_q;
	assign new_mask = {sell_dec.post, sell_dec.cancel, buy_dec.post, buy_dec.cancel};
	assign produces = book_go && (new_mask != 4'd0);
	assign s1_fire  = valid_s1 && (!produces || buf_free);
	assign refresh  = s1_fire && book_go;
	assign pop      = s1_fire && (qcnt_q != 2'd0)
		&& ((cmd_s1 == tsqr_pkg::CMD_ACK) || (cmd_s1 == tsqr_pkg::CMD_REJECT));

	always_comb begin
		buy_ctl         = '0;
		buy_ctl.refresh = refresh;
		buy_ctl.ack     = pop && (cmd_s1 == tsqr_pkg::CMD_ACK) && (qside0_q == tsqr_pkg::SIDE_BUY);
		buy_ctl.reject  = pop && (cmd_s1 == tsqr_pkg::CMD_REJECT)
			&& (qside0_q == tsqr_pkg::SIDE_BUY);
		buy_ctl.fill    = s1_fire && (cmd_s1 == tsqr_pkg::CMD_FILL)
			&& (fside_s1 == tsqr_pkg::SIDE_BUY);
		buy_ctl.id      = id_s1;
		sell_ctl         = '0;
		sell_ctl.refresh = refresh;
		sell_ctl.ack     = pop && (cmd_s1 == tsqr_pkg::CMD_ACK)
			&& (qside0_q == tsqr_pkg::SIDE_SELL);
		sell_ctl.reject  = pop && (cmd_s1 == tsqr_pkg::CMD_REJECT)
			&& (qside0_q == tsqr_pkg::SIDE_SELL);
		sell_ctl.fill    = s1_fire && (cmd_s1 == tsqr_pkg::CMD_FILL)
			&& (fside_s1 == tsqr_pkg::SIDE_SELL);
		sell_ctl.id      = id_s1;
	end

	tsqr_side u_buy (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (buy_ctl),
		.target (buy_tgt),
		.dec    (buy_dec)
	);

	tsqr_side u_sell (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sell_ctl),
		.target (sell_tgt),
		.dec    (sell_dec)
	);

	always_comb begin
		qcnt_n   = qcnt_q;
		qside0_n = qside0_q;
		qside1_n = qside1_q;
		if (pop) begin
			qside0_n = qside1_q;
			qcnt_n   = qcnt_q - 2'd1;
		end
		if (refresh && buy_dec.post && (qcnt_n < 2'd2)) begin
			if (qcnt_n == 2'd0) begin
				qside0_n = tsqr_pkg::SIDE_BUY;
			end else begin
				qside1_n = tsqr_pkg::SIDE_BUY;
			end
			qcnt_n = qcnt_n + 2'd1;
		end
		if (refresh && sell_dec.post && (qcnt_n < 2'd2)) begin
			if (qcnt_n == 2'd0) begin
				qside0_n = tsqr_pkg::SIDE_SELL;
			end else begin
				qside1_n = tsqr_pkg::SIDE_SELL;
			end
			qcnt_n = qcnt_n + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcnt_q <= 2'd0;
		end else begin
			qcnt_q <= qcnt_n;
		end
	end

	always_ff @(posedge clk) begin
		qside0_q <= qside0_n;
		qside1_q <= qside1_n;
	end

	always_comb begin
		if (mask_q[0]) begin
			slot = tsqr_pkg::SLOT_BUY_CANCEL;
		end else if (mask_q[1]) begin
			slot = tsqr_pkg::SLOT_BUY_POST;
		end else if (mask_q[2]) begin
			slot = tsqr_pkg::SLOT_SELL_CANCEL;
		end else begin
			slot = tsqr_pkg::SLOT_SELL_POST;
		end
	end

	assign rest_mask = mask_q & ~(4'd1 << slot);
	assign out_load  = (mask_q != 4'd0) && (!out_valid_q || out_ready);
	assign buf_free  = (mask_q == 4'd0) || ((rest_mask == 4'd0) && out_load);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= 4'd0;
		end else if (refresh && produces) begin
			mask_q <= new_mask;
		end else if (out_load) begin
			mask_q <= rest_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (refresh && produces) begin
			buy_id_q  <= buy_dec.cancel_id;
			sell_id_q <= sell_dec.cancel_id;
			buy_px_q  <= buy_tgt;
			sell_px_q <= sell_tgt;
			time_q    <= time_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_time_q <= time_q;
			last_q     <= (rest_mask == 4'd0);
			case (slot)
				tsqr_pkg::SLOT_BUY_CANCEL: begin
					action_q    <= tsqr_pkg::ACT_CANCEL;
					side_q      <= tsqr_pkg::SIDE_BUY;
					cancel_id_q <= buy_id_q;
					price_q     <= '0;
					qty_q       <= '0;
				end
				tsqr_pkg::SLOT_BUY_POST: begin
					action_q    <= tsqr_pkg::ACT_POST;
					side_q      <= tsqr_pkg::SIDE_BUY;
					cancel_id_q <= '0;
					price_q     <= buy_px_q;
					qty_q       <= qsize_q;
				end
				tsqr_pkg::SLOT_SELL_CANCEL: begin
					action_q    <= tsqr_pkg::ACT_CANCEL;
					side_q      <= tsqr_pkg::SIDE_SELL;
					cancel_id_q <= sell_id_q;
					price_q     <= '0;
					qty_q       <= '0;
				end
				default: begin
					action_q    <= tsqr_pkg::ACT_POST;
					side_q      <= tsqr_pkg::SIDE_SELL;
					cancel_id_q <= '0;
					price_q     <= sell_px_q;
					qty_q       <= qsize_q;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign action      = action_q;
	assign action_side = side_q;
	assign cancel_id   = cancel_id_q;
	assign quote_price = price_q;
	assign quote_qty   = qty_q;
	assign action_time = out_time_q;
	assign last        = last_q;

endmodule

// ===== rtl/core/tsqr_checker.sv =====
// ----------------------------------------------------------------------------
// Two-sided quote refresher checker
// Port-level checks on the result channel, bound to the core.
// ----------------------------------------------------------------------------
`include "two_sided_quote_refresher_core_assert.svh"

module tsqr_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic                                action,
	input logic                                action_side,
	input logic [tsqr_pkg::ID_W-1:0]           cancel_id,
	input logic signed [tsqr_pkg::PRICE_W-1:0] quote_price,
	input logic [tsqr_pkg::QTY_W-1:0]          quote_qty,
	input logic                                last
);

	logic cancel_seen;
	logic post_seen;
	logic cancel_taken;
	logic cancel_clean;

	assign cancel_seen  = out_valid && (action == tsqr_pkg::ACT_CANCEL);
	assign post_seen    = out_valid && (action == tsqr_pkg::ACT_POST);
	assign cancel_taken = cancel_seen && out_ready;
	assign cancel_clean = (quote_price == '0) && (quote_qty == '0) && !last;

	`TSQR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`TSQR_ASSERT_NOW(a_cancel_fields, cancel_seen, cancel_clean)
	`TSQR_ASSERT_NOW(a_post_fields, post_seen, cancel_id == '0)
	`TSQR_ASSERT_NEXT(a_cancel_then_post, cancel_taken, post_seen && (action_side == $past(action_side)))

endmodule

bind two_sided_quote_refresher_core tsqr_checker u_tsqr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.action      (action),
	.action_side (action_side),
	.cancel_id   (cancel_id),
	.quote_price (quote_price),
	.quote_qty   (quote_qty),
	.last        (last)
);
